FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Synthesis builds define SYNTH to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Implication checked in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/tlvst_pkg.sv
package tlvst_pkg;

    localparam int TYPE_W   = 16;
    localparam int LEN_W    = 16;
    localparam int VOFF_W   = 24;
    localparam int STAT_W   = 2;
    localparam int COUNT_W  = 16;
    localparam int BYTE_W   = 8;
    localparam int HDR_W    = 24;
    localparam int TDATA_W  = 80;

    localparam logic [COUNT_W-1:0] MAX_TOKENS_RESET = 16'd16;

    // Result queue depth; must leave room for two results per transaction.
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_BADLEN   = 2'd2
    } status_t;

    typedef struct packed {
        logic               is_summary;
        logic [TYPE_W-1:0]  token_type;
        logic [LEN_W-1:0]   token_length;
        logic [VOFF_W-1:0]  value_offset;
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] token_count;
    } result_t;

    // Up to two results produced by one input byte, in delivery order.
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

endpackage

FILE: rtl/tlvst_parser.sv
`include "assert_macros.svh"

module tlvst_parser
    import tlvst_pkg::*;
#(
    parameter int OFFSET_BITS = 24
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata,
    input  logic               in_accept,
    input  logic [BYTE_W-1:0]  in_byte,
    input  logic               in_final,
    output push_t              push
);

    typedef enum logic [2:0] {
        PH_HDR0   = 3'd0,
        PH_HDR1   = 3'd1,
        PH_HDR2   = 3'd2,
        PH_HDR3   = 3'd3,
        PH_VALUE  = 3'd4,
        PH_IGNORE = 3'd5
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [HDR_W-1:0]       header_shift_reg, header_shift_next;
    logic [TYPE_W-1:0]      record_type_reg, record_type_next;
    logic [LEN_W-1:0]       record_length_reg, record_length_next;
    logic [LEN_W-1:0]       value_remaining_reg, value_remaining_next;
    logic [OFFSET_BITS-1:0] byte_offset_reg, byte_offset_next;
    logic [OFFSET_BITS-1:0] value_start_reg, value_start_next;
    logic [COUNT_W-1:0]     tokens_seen_reg, tokens_seen_next;
    logic [STAT_W-1:0]      error_status_reg, error_status_next;
    logic [COUNT_W-1:0]     max_tokens_reg;

    logic [OFFSET_BITS-1:0]        next_off;
    logic [LEN_W-1:0]              hdr_length;
    logic                          tok_fire;
    logic [STAT_W-1:0]             final_status;
    logic [OFFSET_BITS+VOFF_W-1:0] start_wide;
    result_t                       tok_res;
    result_t                       sum_res;

    always_comb
    begin
        next_off = (byte_offset_reg == {OFFSET_BITS{1'b1}}) ? byte_offset_reg
                                                             : byte_offset_reg + 1'b1;
        hdr_length = {header_shift_reg[BYTE_W-1:0], in_byte};

        phase_next           = phase_reg;
        header_shift_next    = header_shift_reg;
        record_type_next     = record_type_reg;
        record_length_next   = record_length_reg;
        value_remaining_next = value_remaining_reg;
        value_start_next     = value_start_reg;
        error_status_next    = error_status_reg;
        tok_fire             = 1'b0;

        case (phase_reg)
            PH_HDR0, PH_HDR1, PH_HDR2:
            begin
                header_shift_next = {header_shift_reg[HDR_W-BYTE_W-1:0], in_byte};
                phase_next        = phase_t'(phase_reg + 3'd1);
            end
            PH_HDR3:
            begin
                if (tokens_seen_reg >= max_tokens_reg)
                begin
                    error_status_next = ST_OVERFLOW;
                    phase_next        = PH_IGNORE;
                end
                else
                begin
                    record_type_next   = header_shift_reg[HDR_W-1:BYTE_W];
                    record_length_next = hdr_length;
                    value_start_next   = next_off;
                    header_shift_next  = '0;
                    if (hdr_length == '0)
                    begin
                        tok_fire   = 1'b1;
                        phase_next = PH_HDR0;
                    end
                    else
                    begin
                        value_remaining_next = hdr_length;
                        phase_next           = PH_VALUE;
                    end
                end
            end
            PH_VALUE:
            begin
                value_remaining_next = value_remaining_reg - 1'b1;
                if (value_remaining_reg == LEN_W'(1))
                begin
                    tok_fire   = 1'b1;
                    phase_next = PH_HDR0;
                end
            end
            default:
            begin
                // Ignoring everything up to the final byte.
            end
        endcase

        byte_offset_next = next_off;
        tokens_seen_next = tok_fire ? tokens_seen_reg + 1'b1 : tokens_seen_reg;

        if (phase_next == PH_VALUE && error_status_next == ST_OK)
            final_status = ST_BADLEN;
        else
            final_status = error_status_next;

        // Low bits of the value start, zero-extended when the offset is narrow.
        start_wide = {{VOFF_W{1'b0}}, value_start_next};

        tok_res              = '0;
        tok_res.token_type   = record_type_next;
        tok_res.token_length = record_length_next;
        tok_res.value_offset = start_wide[VOFF_W-1:0];

        sum_res             = '0;
        sum_res.is_summary  = 1'b1;
        sum_res.status      = final_status;
        sum_res.token_count = tokens_seen_next;

        push.v0 = in_accept && (tok_fire || in_final);
        push.v1 = in_accept && tok_fire && in_final;
        push.r0 = tok_fire ? tok_res : sum_res;
        push.r1 = sum_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_HDR0;
            header_shift_reg    <= '0;
            record_type_reg     <= '0;
            record_length_reg   <= '0;
            value_remaining_reg <= '0;
            byte_offset_reg     <= '0;
            value_start_reg     <= '0;
            tokens_seen_reg     <= '0;
            error_status_reg    <= ST_OK;
            max_tokens_reg      <= MAX_TOKENS_RESET;
        end
        else
        begin
            if (cfg_we)
                max_tokens_reg <= cfg_wdata;
            if (in_accept)
            begin
                if (in_final)
                begin
                    // End of payload: the next byte starts a fresh parse.
                    phase_reg           <= PH_HDR0;
                    header_shift_reg    <= '0;
                    record_type_reg     <= '0;
                    record_length_reg   <= '0;
                    value_remaining_reg <= '0;
                    byte_offset_reg     <= '0;
                    value_start_reg     <= '0;
                    tokens_seen_reg     <= '0;
                    error_status_reg    <= ST_OK;
                end
                else
                begin
                    phase_reg           <= phase_next;
                    header_shift_reg    <= header_shift_next;
                    record_type_reg     <= record_type_next;
                    record_length_reg   <= record_length_next;
                    value_remaining_reg <= value_remaining_next;
                    byte_offset_reg     <= byte_offset_next;
                    value_start_reg     <= value_start_next;
                    tokens_seen_reg     <= tokens_seen_next;
                    error_status_reg    <= error_status_next;
                end
            end
        end
    end

    `ASSERT_IMPLY(a_value_nonzero, clk, rst_n, phase_reg == PH_VALUE, value_remaining_reg != '0)
    `ASSERT_NEXT(a_final_clears, clk, rst_n, in_accept && in_final, phase_reg == PH_HDR0 && tokens_seen_reg == '0)
    `ASSERT_IMPLY(a_pair_order, clk, rst_n, push.v1, push.v0 && !push.r0.is_summary && push.r1.is_summary)

endmodule

FILE: rtl/tlvst_queue.sv
`include "assert_macros.svh"

module tlvst_queue
    import tlvst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    space_two,
    output logic    head_valid,
    output result_t head,
    input  logic    pop
);

    result_t             mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic [QCNT_W-1:0]   push_cnt;
    logic                do_pop;

    always_comb
    begin
        push_cnt    = QCNT_W'(push.v0) + QCNT_W'(push.v1);
        do_pop      = pop && (count_reg != '0);
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_cnt);
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + push_cnt - QCNT_W'(do_pop);
    end

    assign space_two  = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push.v0)
            mem[wr_ptr_reg] <= push.r0;
        if (push.v1)
            mem[wr_ptr_reg + 1'b1] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= QCNT_W'(QDEPTH))
    `ASSERT_IMPLY(a_no_overrun, clk, rst_n, push_cnt != '0, {1'b0, count_reg} + {1'b0, push_cnt} <= (QCNT_W+1)'(QDEPTH))
    `ASSERT_NEXT(a_pop_only, clk, rst_n, do_pop && push_cnt == '0, count_reg == $past(count_reg) - 1'b1)

endmodule

FILE: rtl/tlv_stream_tokenizer.sv
// TLV stream tokenizer.
// The slave stream carries the payload one byte per transaction; s_tlast marks its
// final byte. Records are a big-endian 16-bit type, a big-endian 16-bit length and
// that many value bytes. The master stream returns token transactions (m_tlast low)
// when a value completes, or on the fourth header byte for a zero length, and one
// summary transaction (m_tlast high) after the final byte with the status and count.
// A byte is parsed in the cycle it is accepted; its results enter a four-entry result
// queue and appear on the master side. A byte may be accepted every cycle s_tready
// is high; a byte that closes both a token and the payload yields two transactions
// and, if the master side keeps up, the queue absorbs the extra one. s_tready is low
// only while fewer than two queue entries are free, which is what a stalled receiver
// causes: results are held in order, none dropped, and the input waits. The user must
// write max_tokens through cfg_we/cfg_wdata only while idle; the block does not
// enforce it. Reset clears the parse state and the queue and sets max_tokens to 16.
module tlv_stream_tokenizer
    import tlvst_pkg::*;
#(
    parameter int OFFSET_BITS = 24
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [COUNT_W-1:0]  cfg_wdata,   // max_tokens
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [BYTE_W-1:0]   s_tdata,     // payload_byte
    input  logic                s_tlast,     // final_byte
    output logic                m_tvalid,
    input  logic                m_tready,
    // token_type, token_length, value_offset, status, token_count, zero fill
    output logic [TDATA_W-1:0]  m_tdata,
    output logic                m_tlast      // is_summary
);

    push_t   push;
    result_t head;
    logic    space_two;
    logic    in_accept;

    assign s_tready  = space_two;
    assign in_accept = s_tvalid && space_two;

    tlvst_parser #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_final  (s_tlast),
        .push      (push)
    );

    tlvst_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .space_two  (space_two),
        .head_valid (m_tvalid),
        .head       (head),
        .pop        (m_tready)
    );

    // Fields packed from the lowest bit up; the top bits are zero.
    assign m_tdata = {6'b0, head.token_count, head.status, head.value_offset,
                      head.token_length, head.token_type};
    assign m_tlast = head.is_summary;

endmodule
